// ===== src/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasteriser package
// Shared constants and command codes for the line rasteriser.
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int COLOR_BITS      = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_UP   = 2'b01;
	localparam logic [1:0] DIR_DOWN = 2'b11;

	function automatic int entry_bits(input int coord_bits);
		return 5 * coord_bits + 6 + COLOR_BITS;
	endfunction

endpackage

// ===== src/lr_front.sv =====
// ----------------------------------------------------------------------------
// Line rasteriser front end
// Takes commands, works out the set-up of a new line and registers the
// resulting work entry for the queue.
// ----------------------------------------------------------------------------
module lr_front #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
	parameter int ENTRY_BITS = lr_pkg::entry_bits(lr_pkg::COORD_BITS_DEF)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic signed [COORD_BITS-1:0]  from_x,
	input  logic signed [COORD_BITS-1:0]  from_y,
	input  logic signed [COORD_BITS-1:0]  to_x,
	input  logic signed [COORD_BITS-1:0]  to_y,
	input  logic [lr_pkg::COLOR_BITS-1:0] line_color,
	output logic                          push,
	output logic [ENTRY_BITS-1:0]         push_data,
	input  logic                          q_full
);

	logic                         valid_s1;
	logic [ENTRY_BITS-1:0]        entry_s1;
	logic                         load;
	logic signed [COORD_BITS:0]   diff_x;
	logic signed [COORD_BITS:0]   diff_y;
	logic [COORD_BITS-1:0]        mag_x;
	logic [COORD_BITS-1:0]        mag_y;
	logic                         steep;
	logic signed [COORD_BITS-1:0] maj0;
	logic signed [COORD_BITS-1:0] maj1;
	logic signed [COORD_BITS-1:0] min0;
	logic signed [COORD_BITS-1:0] min1;
	logic signed [COORD_BITS-1:0] maj_lo;
	logic signed [COORD_BITS-1:0] maj_hi;
	logic signed [COORD_BITS-1:0] min_lo;
	logic signed [COORD_BITS-1:0] min_hi;
	logic [COORD_BITS-1:0]        dmaj;
	logic [COORD_BITS-1:0]        dmin;
	logic [1:0]                   dir;
	logic [COORD_BITS:0]          thr;
	logic [COORD_BITS:0]          inc;
	logic [ENTRY_BITS-1:0]        entry_d;

	assign in_stall  = valid_s1 & q_full;
	assign load      = ~in_stall;
	assign push      = valid_s1 & ~q_full;
	assign push_data = entry_s1;

	always_comb begin
		diff_x = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
		diff_y = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};
		mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
		mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
		steep  = mag_y > mag_x;
		if (steep) begin
			maj0 = from_y;
			maj1 = to_y;
			min0 = from_x;
			min1 = to_x;
			dmaj = mag_y;
			dmin = mag_x;
		end else begin
			maj0 = from_x;
			maj1 = to_x;
			min0 = from_y;
			min1 = to_y;
			dmaj = mag_x;
			dmin = mag_y;
		end
		if (maj0 > maj1) begin
			maj_lo = maj1;
			maj_hi = maj0;
			min_lo = min1;
			min_hi = min0;
		end else begin
			maj_lo = maj0;
			maj_hi = maj1;
			min_lo = min0;
			min_hi = min1;
		end
		if (min_hi > min_lo) begin
			dir = lr_pkg::DIR_UP;
		end else if (min_hi < min_lo) begin
			dir = lr_pkg::DIR_DOWN;
		end else begin
			dir = lr_pkg::DIR_NONE;
		end
		thr = {1'b0, dmaj} + (COORD_BITS+1)'(1);
		inc = {1'b0, dmin} + (COORD_BITS+1)'(1);
		entry_d = {command, steep, maj_lo, maj_hi, min_lo, dir, thr, inc, line_color};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

// ===== src/lr_queue.sv =====
// ----------------------------------------------------------------------------
// Line rasteriser work queue
// Short first-in first-out queue between the front end and the stepper. The
// oldest entry is held in a register of its own and refilled from the array.
// ----------------------------------------------------------------------------
module lr_queue #(
	parameter int WIDTH = lr_pkg::entry_bits(lr_pkg::COORD_BITS_DEF),
	parameter int DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                head_valid_q;
	logic [WIDTH-1:0]    head_q;
	logic                do_pop;
	logic                mem_empty;
	logic                to_head;
	logic                mem_wr;
	logic                mem_rd;

	assign full       = count_q == CNT_BITS'(DEPTH);
	assign head_valid = head_valid_q;
	assign head_data  = head_q;
	assign do_pop     = pop & head_valid_q;
	assign mem_empty  = count_q <= CNT_BITS'(1);
	assign to_head    = push & (~head_valid_q | (do_pop & mem_empty));
	assign mem_wr     = push & ~to_head;
	assign mem_rd     = do_pop & ~mem_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (mem_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (mem_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (to_head || mem_rd) begin
				head_valid_q <= 1'b1;
			end else if (do_pop) begin
				head_valid_q <= 1'b0;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (to_head) begin
			head_q <= push_data;
		end else if (mem_rd) begin
			head_q <= mem_q[rd_ptr_q];
		end
	end

endmodule

// ===== src/lr_back.sv =====
// ----------------------------------------------------------------------------
// Line rasteriser stepper
// Holds the line being drawn, runs the error term and registers one pixel
// per step.
// ----------------------------------------------------------------------------
module lr_back #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
	parameter int ENTRY_BITS = lr_pkg::entry_bits(lr_pkg::COORD_BITS_DEF)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  logic [ENTRY_BITS-1:0]         head_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                          last_pixel
);

	logic                          e_cmd;
	logic                          e_steep;
	logic signed [COORD_BITS-1:0]  e_maj_lo;
	logic signed [COORD_BITS-1:0]  e_maj_hi;
	logic signed [COORD_BITS-1:0]  e_min_lo;
	logic [1:0]                    e_dir;
	logic [COORD_BITS:0]           e_thr;
	logic [COORD_BITS:0]           e_inc;
	logic [lr_pkg::COLOR_BITS-1:0] e_color;

	logic                          busy_q;
	logic                          steep_q;
	logic signed [COORD_BITS-1:0]  major_pos_q;
	logic signed [COORD_BITS-1:0]  minor_pos_q;
	logic signed [COORD_BITS-1:0]  major_end_q;
	logic [1:0]                    minor_dir_q;
	logic [COORD_BITS+1:0]         err_q;
	logic [COORD_BITS:0]           thr_q;
	logic [COORD_BITS:0]           inc_q;
	logic [lr_pkg::COLOR_BITS-1:0] color_q;

	logic                          out_valid_q;
	logic signed [COORD_BITS-1:0]  pixel_x_q;
	logic signed [COORD_BITS-1:0]  pixel_y_q;
	logic [lr_pkg::COLOR_BITS-1:0] pixel_color_q;
	logic                          last_pixel_q;

	logic                          out_free;
	logic                          is_start;
	logic                          emit;
	logic                          last;
	logic [COORD_BITS+1:0]         err_sum;
	logic                          wrap;

	assign {e_cmd, e_steep, e_maj_lo, e_maj_hi, e_min_lo, e_dir, e_thr, e_inc, e_color} =
		head_data;

	assign out_free = ~out_valid_q | ~out_stall;
	assign is_start = e_cmd == lr_pkg::CMD_START;
	assign pop      = head_valid & (is_start | ~busy_q | out_free);
	assign emit     = head_valid & ~is_start & busy_q & out_free;
	assign last     = major_pos_q >= major_end_q;
	assign err_sum  = err_q + {1'b0, inc_q};
	assign wrap     = err_sum >= {1'b0, thr_q};

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last_pixel  = last_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && is_start) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_start) begin
			steep_q     <= e_steep;
			major_pos_q <= e_maj_lo;
			major_end_q <= e_maj_hi;
			minor_pos_q <= e_min_lo;
			minor_dir_q <= e_dir;
			thr_q       <= e_thr;
			inc_q       <= e_inc;
			err_q       <= {2'b00, e_inc[COORD_BITS:1]};
			color_q     <= e_color;
		end else if (emit && !last) begin
			major_pos_q <= major_pos_q + COORD_BITS'(1);
			if (wrap) begin
				minor_pos_q <= minor_pos_q + {{(COORD_BITS-2){minor_dir_q[1]}}, minor_dir_q};
				err_q       <= err_sum - {1'b0, thr_q};
			end else begin
				err_q <= err_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q     <= steep_q ? minor_pos_q : major_pos_q;
			pixel_y_q     <= steep_q ? major_pos_q : minor_pos_q;
			pixel_color_q <= color_q;
			last_pixel_q  <= last;
		end
	end

endmodule

// ===== src/line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Line rasteriser
// Draws a straight segment between two signed endpoints, one pixel per step.
// ----------------------------------------------------------------------------
// A start command latches both endpoints and the colour; each following step
// command gives the next pixel of the line, both ends included, with the final
// pixel flagged. Start commands give no pixel, and a step with no line in
// progress is dropped. The block sustains one command per clock cycle, so one
// pixel per cycle while steps arrive back to back and out_stall is low; that
// figure is set by the stepper, which advances the error term once per cycle. A
// step's pixel passes through the front end's entry register, the queue and
// the stepper's pixel registers, and a queue of QUEUE_DEPTH entries lets the
// command side keep transferring while the pixel side stalls.
module line_rasterizer_unit #(
	parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic signed [COORD_BITS-1:0]  from_x,
	input  logic signed [COORD_BITS-1:0]  from_y,
	input  logic signed [COORD_BITS-1:0]  to_x,
	input  logic signed [COORD_BITS-1:0]  to_y,
	input  logic [lr_pkg::COLOR_BITS-1:0] line_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                          last_pixel
);

	localparam int ENTRY_BITS = lr_pkg::entry_bits(COORD_BITS);

	logic                  push;
	logic [ENTRY_BITS-1:0] push_data;
	logic                  q_full;
	logic                  pop;
	logic                  head_valid;
	logic [ENTRY_BITS-1:0] head_data;

	lr_front #(
		.COORD_BITS(COORD_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.line_color(line_color),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	lr_queue #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	lr_back #(
		.COORD_BITS(COORD_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel)
	);

endmodule
